>>> rtl/core/itp_pkg.sv
// Shared types and constants for the interrupt table entry parser.
package itp_pkg;

  localparam int unsigned HeaderBytes  = 44;
  localparam int unsigned IdSlots      = 64;
  localparam int unsigned MaxCpusDef   = 64;
  localparam int unsigned QueueDepthDef = 4;

  localparam int unsigned OutDataW = 88;

  typedef enum logic [1:0] {
    EV_CPU   = 2'd0,
    EV_IO    = 2'd1,
    EV_DONE  = 2'd2,
    EV_ABORT = 2'd3
  } event_e;

  // Results caused by one table byte: a first result and an optional closing one.
  typedef struct packed {
    event_e      ev_a;
    logic [5:0]  cpu_index;
    logic [7:0]  apic_id;
    logic [31:0] io_addr;
    logic [31:0] local_addr;
    logic [6:0]  cpu_total;
    logic        two;
    event_e      ev_b;
  } rec_t;

endpackage

>>> rtl/core/itp_front.sv
// Front end: walks the table bytes, tracks header and entry state, builds result records.
module itp_front #(
  parameter int unsigned MAX_CPUS = itp_pkg::MaxCpusDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [7:0]   byte_i,
  input  logic         first_i,
  input  logic         full_i,
  output logic         push_o,
  output itp_pkg::rec_t rec_o
);
  import itp_pkg::*;

  localparam int unsigned Limit = (MAX_CPUS < IdSlots) ? MAX_CPUS : IdSlots;
  localparam logic [6:0] LimitW = 7'(Limit);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ENTRIES = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] dlen_q, dlen_d;
  logic [31:0] laddr_q, laddr_d;
  logic [7:0]  off_q, off_d;
  logic [7:0]  etype_q, etype_d;
  logic [7:0]  elen_q, elen_d;
  logic [31:0] gather_q, gather_d;
  logic [31:0] ioaddr_q, ioaddr_d;
  logic [6:0]  cnt_q, cnt_d;

  logic   fire;
  logic   has_a, ends;
  event_e ev_a, ev_end;
  logic [5:0] slot;

  assign ready_o = !full_i;
  assign fire    = valid_i && ready_o;

  always_comb begin
    phase_e      ph_c;
    logic [31:0] pos_c;
    logic [8:0]  off_nx;
    ph_c     = first_i ? PH_HEADER : phase_q;
    pos_c    = first_i ? 32'd0 : pos_q;
    dlen_d   = first_i ? 32'd0 : dlen_q;
    laddr_d  = first_i ? 32'd0 : laddr_q;
    off_d    = first_i ? 8'd0 : off_q;
    etype_d  = first_i ? 8'd0 : etype_q;
    elen_d   = first_i ? 8'd0 : elen_q;
    gather_d = first_i ? 32'd0 : gather_q;
    ioaddr_d = first_i ? 32'd0 : ioaddr_q;
    cnt_d    = first_i ? 7'd0 : cnt_q;
    phase_d  = ph_c;
    off_nx   = {1'b0, off_d} + 9'd1;
    has_a    = 1'b0;
    ev_a     = EV_CPU;
    ends     = 1'b0;
    ev_end   = EV_DONE;
    slot     = cnt_d[5:0];

    case (ph_c)
      PH_HEADER: begin
        if (pos_c >= 32'd4 && pos_c <= 32'd7) begin
          dlen_d = dlen_d | (32'(byte_i) << {pos_c[1:0], 3'b000});
        end else if (pos_c >= 32'd36 && pos_c <= 32'd39) begin
          laddr_d = laddr_d | (32'(byte_i) << {pos_c[1:0], 3'b000});
        end
        if (pos_c == 32'(HeaderBytes - 1)) begin
          off_d = 8'd0;
          if (dlen_d <= 32'(HeaderBytes)) begin
            ends    = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_ENTRIES;
          end
        end
      end
      PH_ENTRIES: begin
        if (off_d == 8'd0) begin
          etype_d = byte_i;
          off_d   = 8'd1;
        end else if (off_d == 8'd1) begin
          elen_d = byte_i;
          if (byte_i == 8'd0) begin
            ends    = 1'b1;
            ev_end  = EV_ABORT;
            phase_d = PH_DONE;
          end else if (byte_i == 8'd1) begin
            // length byte doubles as the type byte of the next entry
            if (pos_c >= dlen_d) begin
              ends    = 1'b1;
              phase_d = PH_DONE;
            end else begin
              etype_d = byte_i;
              off_d   = 8'd1;
            end
          end else if (byte_i == 8'd2) begin
            off_d = 8'd0;
            if ({1'b0, pos_c} + 33'd1 >= {1'b0, dlen_d}) begin
              ends    = 1'b1;
              phase_d = PH_DONE;
            end
          end else begin
            off_d = 8'd2;
          end
        end else begin
          if (etype_d == 8'd0 && off_d == 8'd3 && elen_d >= 8'd4) begin
            if (cnt_d < LimitW) begin
              cnt_d = cnt_d + 7'd1;
              has_a = 1'b1;
              ev_a  = EV_CPU;
            end
          end else if (etype_d == 8'd1 && off_d >= 8'd4 && off_d <= 8'd7
                       && elen_d >= 8'd8) begin
            if (off_d == 8'd4) begin
              gather_d = 32'd0;
            end
            gather_d = gather_d | (32'(byte_i) << {off_d[1:0], 3'b000});
            if (off_d == 8'd7) begin
              ioaddr_d = gather_d;
              has_a    = 1'b1;
              ev_a     = EV_IO;
            end
          end
          if (off_nx >= {1'b0, elen_d}) begin
            off_d = 8'd0;
            if ({1'b0, pos_c} + 33'd1 >= {1'b0, dlen_d}) begin
              ends    = 1'b1;
              phase_d = PH_DONE;
            end
          end else begin
            off_d = off_nx[7:0];
          end
        end
      end
      default: begin
      end
    endcase

    pos_d = (pos_c != '1) ? pos_c + 32'd1 : pos_c;
  end

  always_comb begin
    rec_o.ev_a       = has_a ? ev_a : ev_end;
    rec_o.cpu_index  = (has_a && ev_a == EV_CPU) ? slot : 6'd0;
    rec_o.apic_id    = (has_a && ev_a == EV_CPU) ? byte_i : 8'd0;
    rec_o.io_addr    = ioaddr_d;
    rec_o.local_addr = laddr_d;
    rec_o.cpu_total  = cnt_d;
    rec_o.two        = has_a && ends;
    rec_o.ev_b       = ev_end;
  end

  assign push_o = fire && (has_a || ends);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pos_q    <= '0;
      dlen_q   <= '0;
      laddr_q  <= '0;
      off_q    <= '0;
      etype_q  <= '0;
      elen_q   <= '0;
      gather_q <= '0;
      ioaddr_q <= '0;
      cnt_q    <= '0;
    end else if (fire) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      dlen_q   <= dlen_d;
      laddr_q  <= laddr_d;
      off_q    <= off_d;
      etype_q  <= etype_d;
      elen_q   <= elen_d;
      gather_q <= gather_d;
      ioaddr_q <= ioaddr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !first_i && phase_q == PH_DONE |-> !push_o)
    else $error("result produced after walk ended");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LimitW)
    else $error("processor count above limit");

  a_end_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ends |=> phase_q == PH_DONE)
    else $error("walk end without done phase");

endmodule

>>> rtl/core/itp_queue.sv
// Short record queue between the parsing front end and the output stage.
module itp_queue #(
  parameter int unsigned DEPTH = itp_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  itp_pkg::rec_t rec_i,
  input  logic          pop_i,
  output itp_pkg::rec_t rec_o,
  output logic          full_o,
  output logic          empty_o
);
  import itp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthC  = CntW'(DEPTH);

  rec_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == DepthC;
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count did not advance on push");

endmodule

>>> rtl/core/itp_back.sv
// Output stage: unpacks queued records into one or two result transactions.
module itp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  itp_pkg::rec_t rec_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [1:0]    event_o,
  output logic [5:0]    cpu_index_o,
  output logic [7:0]    apic_id_o,
  output logic [31:0]   io_addr_o,
  output logic [31:0]   local_addr_o,
  output logic [6:0]    cpu_total_o,
  output logic          last_o
);
  import itp_pkg::*;

  logic        valid_q;
  logic        pend_q;
  event_e      ev_q, evb_q;
  logic [5:0]  idx_q;
  logic [7:0]  id_q;
  logic [31:0] io_q, la_q;
  logic [6:0]  tot_q;
  logic        last_q;
  logic        load;

  assign load  = !valid_q || ready_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (load) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else begin
        valid_q <= !empty_i;
        pend_q  <= !empty_i && rec_i.two;
      end
    end
  end

  // Payload needs no reset; the closing result keeps the snapshot fields.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_q) begin
        ev_q   <= evb_q;
        idx_q  <= 6'd0;
        id_q   <= 8'd0;
        last_q <= 1'b1;
      end else if (!empty_i) begin
        ev_q   <= rec_i.ev_a;
        idx_q  <= rec_i.cpu_index;
        id_q   <= rec_i.apic_id;
        io_q   <= rec_i.io_addr;
        la_q   <= rec_i.local_addr;
        tot_q  <= rec_i.cpu_total;
        last_q <= !rec_i.two;
        evb_q  <= rec_i.ev_b;
      end
    end
  end

  assign valid_o      = valid_q;
  assign event_o      = ev_q;
  assign cpu_index_o  = idx_q;
  assign apic_id_o    = id_q;
  assign io_addr_o    = io_q;
  assign local_addr_o = la_q;
  assign cpu_total_o  = tot_q;
  assign last_o       = last_q;

  a_pend_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> valid_q && !last_q)
    else $error("closing result pending without first shown");

  a_no_pop_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_o)
    else $error("queue popped while closing result pending");

  a_close_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && ready_i |=> valid_q && last_q && idx_q == 6'd0)
    else $error("closing result not issued after first");

endmodule

>>> rtl/core/interrupt_table_entry_parser.sv
// Top level of the interrupt table entry parser: front end, record queue, output stage.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid_i/tready_o      | tdata: table_byte, tuser: first_byte
//  m_axis   | out | m_axis_tvalid_o/tready_i      | tdata: result fields, tuser: event_res,
//           |     |                               | tlast: last
//
// One table byte is taken per cycle; the front end updates all parse state as each byte is taken.
// A byte that reports an event and ends the walk gives two results, which the output stage
// sends one after the other, popping no record from the queue until the second is sent.
// The queue of QUEUE_DEPTH records absorbs output stalls; input stalls only when it is full.
// Reset clears all parse state and empties the queue; no clearing pass is needed.
module interrupt_table_entry_parser #(
  parameter int unsigned MAX_CPUS    = itp_pkg::MaxCpusDef,
  parameter int unsigned QUEUE_DEPTH = itp_pkg::QueueDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // [7:0] table_byte
  input  logic                         s_axis_tuser_i,  // [0] first_byte
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [5:0] cpu_index, [13:6] apic_id, [45:14] io_controller_address,
  // [77:46] local_controller_address, [84:78] cpu_total, [87:85] zero
  output logic [itp_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic [1:0]                   m_axis_tuser_o,  // [1:0] event_res
  output logic                         m_axis_tlast_o
);
  import itp_pkg::*;

  rec_t        push_rec, head_rec;
  logic        push, pop, full, empty;
  logic [5:0]  cpu_index;
  logic [7:0]  apic_id;
  logic [31:0] io_addr, local_addr;
  logic [6:0]  cpu_total;

  itp_front #(
    .MAX_CPUS (MAX_CPUS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .byte_i  (s_axis_tdata_i),
    .first_i (s_axis_tuser_i),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  itp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .pop_i   (pop),
    .rec_o   (head_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  itp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (head_rec),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .event_o      (m_axis_tuser_o),
    .cpu_index_o  (cpu_index),
    .apic_id_o    (apic_id),
    .io_addr_o    (io_addr),
    .local_addr_o (local_addr),
    .cpu_total_o  (cpu_total),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, cpu_total, local_addr, io_addr, apic_id, cpu_index};

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the interrupt table entry parser: directed tables, then random ones.
module testbench;
  import itp_pkg::*;

  localparam int unsigned MaxCpus     = MaxCpusDef;
  localparam int unsigned IdLimit     = (MaxCpus < IdSlots) ? MaxCpus : IdSlots;
  localparam int          IdlePct     = 17;
  localparam int          RandomBytes = 1300;
  localparam int          CycleLimit  = 400000;
  localparam int          NumRows     = 12;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_ENTRIES = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  typedef struct packed {
    event_e      ev;
    logic [5:0]  cpu_index;
    logic [7:0]  apic_id;
    logic [31:0] io_addr;
    logic [31:0] local_addr;
    logic [6:0]  cpu_total;
    logic        last;
  } result_t;

  // One directed table: header fields, entry bytes after the header, typed-in closing event.
  typedef struct packed {
    logic             first;
    logic [31:0]      length;
    logic [31:0]      laddr;
    logic [7:0]       body_n;
    logic [0:15][7:0] body;
    logic             chk;
    event_e           closing;
  } table_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  interrupt_table_entry_parser #(
    .MAX_CPUS    (MaxCpus),
    .QUEUE_DEPTH (QueueDepthDef)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // Parser state mirrored by the predictor.
  logic [31:0] byte_pos;
  logic [31:0] decl_len;
  logic [31:0] local_addr;
  logic [7:0]  entry_off;
  logic [7:0]  entry_type;
  logic [7:0]  entry_len;
  logic [31:0] addr_gather;
  logic [31:0] io_addr;
  logic [6:0]  cpu_cnt;
  phase_e      phase;

  result_t     byte_results [2];
  int          n_byte_results;
  result_t     pending_results [$];
  result_t     want_r;
  int          bytes_sent   = 0;
  int          errors       = 0;
  int          cycle_cnt    = 0;
  bit          steady       = 1'b0;
  bit          closing_got;
  event_e      closing_seen;
  table_row_t  dir_rows [NumRows];

  task clear_parse_state();
    byte_pos    = '0;
    decl_len    = '0;
    local_addr  = '0;
    entry_off   = '0;
    entry_type  = '0;
    entry_len   = '0;
    addr_gather = '0;
    io_addr     = '0;
    cpu_cnt     = '0;
    phase       = PH_HEADER;
  endtask

  task note_event(input event_e ev, input logic [5:0] idx, input logic [7:0] id);
    byte_results[n_byte_results] = '{ev, idx, id, io_addr, local_addr, cpu_cnt, 1'b0};
    n_byte_results++;
  endtask

  // Entry ends on this byte; report completion once the declared length is reached.
  task close_entry(input logic [31:0] pos);
    entry_off = '0;
    if ({1'b0, pos} + 33'd1 >= {1'b0, decl_len}) begin
      note_event(EV_DONE, '0, '0);
      phase = PH_DONE;
    end
  endtask

  task automatic parse_table_byte(input logic [7:0] b, input logic first);
    logic [31:0] pos;
    logic [7:0]  off;
    if (first) clear_parse_state();
    n_byte_results = 0;
    pos = byte_pos;
    case (phase)
      PH_HEADER: begin
        if (pos >= 4 && pos <= 7) decl_len |= 32'(b) << (8 * (pos - 4));
        else if (pos >= 36 && pos <= 39) local_addr |= 32'(b) << (8 * (pos - 36));
        if (pos == HeaderBytes - 1) begin
          entry_off = '0;
          if (decl_len <= HeaderBytes) begin
            note_event(EV_DONE, '0, '0);
            phase = PH_DONE;
          end else begin
            phase = PH_ENTRIES;
          end
        end
      end
      PH_ENTRIES: begin
        off = entry_off;
        if (off == 8'd0) begin
          entry_type = b;
          entry_off  = 8'd1;
        end else if (off == 8'd1) begin
          entry_len = b;
          if (b == 8'd0) begin
            note_event(EV_ABORT, '0, '0);
            phase = PH_DONE;
          end else if (b == 8'd1) begin
            // previous entry ended at its type byte; this byte is the next type
            if (pos >= decl_len) begin
              note_event(EV_DONE, '0, '0);
              phase = PH_DONE;
            end else begin
              entry_type = b;
              entry_off  = 8'd1;
            end
          end else if (b == 8'd2) begin
            close_entry(pos);
          end else begin
            entry_off = 8'd2;
          end
        end else begin
          if (entry_type == 8'd0 && off == 8'd3 && entry_len >= 8'd4) begin
            if (cpu_cnt < IdLimit) begin
              cpu_cnt = cpu_cnt + 7'd1;
              note_event(EV_CPU, 6'(cpu_cnt - 7'd1), b);
            end
          end else if (entry_type == 8'd1 && off >= 8'd4 && off <= 8'd7 && entry_len >= 8'd8) begin
            if (off == 8'd4) addr_gather = '0;
            addr_gather |= 32'(b) << (8 * (off - 8'd4));
            if (off == 8'd7) begin
              io_addr = addr_gather;
              note_event(EV_IO, '0, '0);
            end
          end
          if (9'(off) + 9'd1 >= 9'(entry_len)) close_entry(pos);
          else entry_off = off + 8'd1;
        end
      end
      default: ;
    endcase
    if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;
    if (n_byte_results > 0) byte_results[n_byte_results - 1].last = 1'b1;
    for (int i = 0; i < n_byte_results; i++) pending_results.push_back(byte_results[i]);
  endtask

  // Offer one byte, idling at random first; predict once the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < (steady ? 0 : IdlePct)) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tuser_i  <= first;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
    parse_table_byte(b, first);
  endtask

  task automatic send_header(input logic [31:0] len, input logic [31:0] laddr, input logic first);
    logic [7:0] b;
    for (int p = 0; p < HeaderBytes; p++) begin
      if (p >= 4 && p <= 7) b = len[8*(p-4) +: 8];
      else if (p >= 36 && p <= 39) b = laddr[8*(p-36) +: 8];
      else b = 8'($urandom);
      send_byte(b, first && p == 0);
    end
  endtask

  // Mostly well-formed tables with random content; some broken lengths and stray restarts.
  task automatic send_random_table(input bit crowd);
    logic [7:0]  body_q [$];
    logic [31:0] len;
    logic [7:0]  etype;
    logic [7:0]  elen;
    int          n_ent;
    int          pick;
    n_ent = crowd ? 70 : $urandom_range(1, 12);
    for (int e = 0; e < n_ent; e++) begin
      pick = $urandom_range(99);
      if (crowd || pick < 40) etype = 8'd0;
      else if (pick < 70) etype = 8'd1;
      else etype = 8'($urandom_range(2, 255));
      pick = $urandom_range(99);
      if (crowd) elen = 8'd4;
      else if (pick >= 85) elen = 8'($urandom_range(0, 9));
      else if (etype == 8'd0) elen = 8'($urandom_range(4, 8));
      else if (etype == 8'd1) elen = 8'($urandom_range(8, 12));
      else elen = 8'($urandom_range(2, 16));
      body_q.push_back(etype);
      body_q.push_back(elen);
      for (int k = 2; k < elen; k++) body_q.push_back(8'($urandom));
    end
    pick = $urandom_range(99);
    if (pick < 75) len = HeaderBytes + body_q.size();
    else if (pick < 85) len = $urandom_range(0, HeaderBytes);
    else if (pick < 95) len = HeaderBytes + $urandom_range(0, body_q.size());
    else len = $urandom;
    send_header(len, $urandom, $urandom_range(99) < 92);
    foreach (body_q[k]) send_byte(body_q[k], $urandom_range(149) == 0);
    repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
  endtask

  task check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      closing_got  = 1'b1;
      closing_seen = event_e'(m_axis_tuser_o);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, event %0d, tdata %0h", $time, m_axis_tuser_o,
                 m_axis_tdata_o);
        errors++;
      end else begin
        want_r = pending_results.pop_front();
        check_field("event_res", 32'(want_r.ev), 32'(m_axis_tuser_o));
        check_field("cpu_index", 32'(want_r.cpu_index), 32'(m_axis_tdata_o[5:0]));
        check_field("apic_id", 32'(want_r.apic_id), 32'(m_axis_tdata_o[13:6]));
        check_field("io_controller_address", want_r.io_addr, m_axis_tdata_o[45:14]);
        check_field("local_controller_address", want_r.local_addr, m_axis_tdata_o[77:46]);
        check_field("cpu_total", 32'(want_r.cpu_total), 32'(m_axis_tdata_o[84:78]));
        check_field("last", 32'(want_r.last), 32'(m_axis_tlast_o));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= (steady ? 0 : IdlePct));
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int random_start;
    int tbl_idx;
    table_row_t row;

    // first row: no first byte after reset, short table
    dir_rows[0]  = '{1'b0, 32'd44, 32'hFEE0_0000, 8'd0, 128'h0, 1'b1, EV_DONE};
    // zero length, bytes after completion are ignored
    dir_rows[1]  = '{1'b1, 32'd0, 32'hFFFF_FFFF, 8'd2, 128'h0, 1'b1, EV_DONE};
    // zero entry length aborts; trailing bytes ignored
    dir_rows[2]  = '{1'b1, 32'hFFFF_FFFF, 32'd0, 8'd4,
                     128'h00_00_01_08_00_00_00_00_00_00_00_00_00_00_00_00, 1'b1, EV_ABORT};
    // processor with the largest id
    dir_rows[3]  = '{1'b1, 32'd52, 32'h1234_5678, 8'd8,
                     128'h00_08_00_FF_01_00_00_00_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // shortest processor entry closes the table on its id byte
    dir_rows[4]  = '{1'b1, 32'd48, 32'hA5A5_5A5A, 8'd4,
                     128'h00_04_01_00_00_00_00_00_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // io controller closes the table on its last address byte
    dir_rows[5]  = '{1'b1, 32'd52, 32'h0000_0001, 8'd8,
                     128'h01_08_02_00_78_56_34_12_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // all-ones io address in a longer entry
    dir_rows[6]  = '{1'b1, 32'd56, 32'h8000_0000, 8'd12,
                     128'h01_0C_03_00_FF_FF_FF_FF_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // processor and io entries too short to hold their fields
    dir_rows[7]  = '{1'b1, 32'd54, 32'hCAFE_F00D, 8'd10,
                     128'h00_03_01_01_07_00_00_00_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // length one twice: once continuing the walk, once ending it
    dir_rows[8]  = '{1'b1, 32'd54, 32'h0F0F_0F0F, 8'd11,
                     128'h05_01_08_00_00_EF_BE_AD_DE_7F_01_00_00_00_00_00, 1'b1, EV_DONE};
    // length two and an unknown type are skipped
    dir_rows[9]  = '{1'b1, 32'd50, 32'hDEAD_BEEF, 8'd7,
                     128'h02_02_7F_03_AA_33_02_00_00_00_00_00_00_00_00_00, 1'b1, EV_DONE};
    // entry runs past the declared length and is still read to its end
    dir_rows[10] = '{1'b1, 32'd46, 32'h7654_3210, 8'd8,
                     128'h01_08_00_00_11_22_33_44_00_00_00_00_00_00_00_00, 1'b0, EV_DONE};
    // processor found, then the walk aborts
    dir_rows[11] = '{1'b1, 32'd100, 32'h0000_FFFF, 8'd10,
                     128'h00_08_05_2A_01_00_00_00_03_00_00_00_00_00_00_00, 1'b1, EV_ABORT};

    clear_parse_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      row = dir_rows[r];
      closing_got = 1'b0;
      send_header(row.length, row.laddr, row.first);
      for (int k = 0; k < row.body_n; k++) send_byte(row.body[k], 1'b0);
      s_axis_tvalid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      if (row.chk && (!closing_got || closing_seen != row.closing)) begin
        $display("%0t: table %0d closing event expected %0d, actual %0d (seen %0b)", $time, r,
                 row.closing, closing_seen, closing_got);
        errors++;
      end
    end

    random_start = bytes_sent;
    tbl_idx = 0;
    while (bytes_sent < random_start + RandomBytes) begin
      steady = (tbl_idx >= 10 && tbl_idx < 16);
      send_random_table(tbl_idx == 3 || $urandom_range(99) < 4);
      tbl_idx++;
    end
    steady = 1'b0;
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/itp_pkg.sv
rtl/core/itp_front.sv
rtl/core/itp_queue.sv
rtl/core/itp_back.sv
rtl/core/interrupt_table_entry_parser.sv
tb/sv/testbench.sv
